>>> sv/sacl_pkg.sv
// Shared types and constants for the set-associative cache model.
`timescale 1ns / 1ps
package sacl_pkg;
  localparam int MaxSetBits = 6;
  localparam int MaxWays    = 8;
  localparam int AddrBits   = 48;
  localparam int NumSets    = 1 << MaxSetBits;
  localparam int WayW       = $clog2(MaxWays);
  localparam int WaysCfgW   = 4;
  localparam int SetW       = MaxSetBits;
  localparam int QDepth     = 2;

  localparam logic [1:0] OpModify = 2'd2;
  localparam logic [1:0] CfgSetBits   = 2'd0;
  localparam logic [1:0] CfgWaysInUse = 2'd1;
  localparam logic [1:0] CfgBlockBits = 2'd2;

  typedef struct packed {
    logic [1:0]          op;
    logic [AddrBits-1:0] address;
  } in_item_t;

  typedef struct packed {
    logic        hit;
    logic        miss;
    logic        eviction;
    logic        second_hit;
    logic [31:0] hit_total;
    logic [31:0] miss_total;
    logic [31:0] eviction_total;
  } out_item_t;

  // classified access passed from front to back
  typedef struct packed {
    logic                modify;
    logic [SetW-1:0]     set;
    logic [AddrBits-1:0] tag;
    logic [WaysCfgW-1:0] ways;
  } acc_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_UPDATE
  } back_state_t;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [1:0] n);
    logic [32:0] s;
    s = {1'b0, a} + {31'd0, n};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction
endpackage

>>> sv/sacl_front.sv
// Front end: accepts accesses, splits address into set and tag, queues them.
`timescale 1ns / 1ps
module sacl_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  input  sacl_pkg::in_item_t   in_data,
  output logic                 in_full,
  input  logic [2:0]           set_bits_r,
  input  logic [3:0]           ways_in_use_r,
  input  logic [4:0]           block_bits_r,
  output logic                 q_valid,
  output sacl_pkg::acc_t       q_data,
  input  logic                 q_take
);
  sacl_pkg::acc_t q_mem_r [sacl_pkg::QDepth];
  logic wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  logic [2:0] s;
  logic [sacl_pkg::AddrBits-1:0] blk, setmask;
  sacl_pkg::acc_t acc;
  logic push_ok, pop_ok;

  always_comb begin
    s = (set_bits_r > 3'(sacl_pkg::MaxSetBits)) ? 3'(sacl_pkg::MaxSetBits) : set_bits_r;
    blk = in_data.address >> block_bits_r;
    setmask = ({sacl_pkg::AddrBits{1'b1}} << s);
    acc.modify = (in_data.op == sacl_pkg::OpModify);
    acc.set = sacl_pkg::SetW'(blk & ~setmask);
    acc.tag = blk >> s;
    if (ways_in_use_r == 4'd0) acc.ways = 4'd1;
    else if (ways_in_use_r > 4'(sacl_pkg::MaxWays)) acc.ways = 4'(sacl_pkg::MaxWays);
    else acc.ways = ways_in_use_r;
  end

  assign in_full = (cnt_r == 2'(sacl_pkg::QDepth));
  assign push_ok = in_push && !in_full;
  assign q_valid = (cnt_r != 2'd0);
  assign pop_ok  = q_take && q_valid;
  assign q_data  = q_mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push_ok) wr_ptr_r <= ~wr_ptr_r;
      if (pop_ok) rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, push_ok} - {1'b0, pop_ok};
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) q_mem_r[wr_ptr_r] <= acc;
  end
endmodule

>>> sv/sacl_back.sv
// Back end: set lookup, LRU replacement, counters and result register.
`timescale 1ns / 1ps
module sacl_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  sacl_pkg::acc_t       q_data,
  output logic                 q_take,
  output logic                 out_empty,
  input  logic                 out_pop,
  output sacl_pkg::out_item_t  out_data
);
  typedef struct packed {
    logic [sacl_pkg::MaxWays-1:0]       valid;
    logic [sacl_pkg::MaxWays-1:0][47:0] tag;
    logic [sacl_pkg::MaxWays-1:0][31:0] stamp;
  } row_t;

  row_t set_mem [sacl_pkg::NumSets];
  logic [31:0] cnt_mem [sacl_pkg::NumSets];
  logic [sacl_pkg::NumSets-1:0] set_seen_r; // set touched since reset
  row_t row_rd_r;
  logic [31:0] cnt_rd_r;
  sacl_pkg::acc_t acc_r;
  sacl_pkg::back_state_t state_r, state_nxt;
  logic [31:0] hits_r, misses_r, evicts_r;
  logic [31:0] hits_nxt, misses_nxt, evicts_nxt;
  logic out_full_r;
  sacl_pkg::out_item_t out_r, res;
  row_t row, row_nxt;
  logic [31:0] now;
  logic hit, found, evict;
  logic [sacl_pkg::WayW-1:0] hit_w, free_w, lru_w, pick;
  logic do_read, do_update;
  // LRU search tree nodes: candidate way, its stamp and whether it is in use
  logic [sacl_pkg::WayW-1:0] lvl_w [sacl_pkg::MaxWays];
  logic [31:0] lvl_s [sacl_pkg::MaxWays];
  logic [sacl_pkg::MaxWays-1:0] lvl_ok;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sacl_pkg::ST_IDLE:   if (q_valid && !out_full_r) state_nxt = sacl_pkg::ST_READ;
      sacl_pkg::ST_READ:   state_nxt = sacl_pkg::ST_UPDATE;
      sacl_pkg::ST_UPDATE: state_nxt = sacl_pkg::ST_IDLE;
      default:             state_nxt = sacl_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    do_read = 1'b0;
    do_update = 1'b0;
    case (state_r)
      sacl_pkg::ST_IDLE:   do_read = q_valid && !out_full_r;
      sacl_pkg::ST_UPDATE: do_update = 1'b1;
      default: ;
    endcase
  end
  assign q_take = do_read;

  // lookup on the registered set row
  always_comb begin
    row = row_rd_r;
    if (!set_seen_r[acc_r.set]) row = '0;
    now = (set_seen_r[acc_r.set] ? cnt_rd_r : 32'd0) + 32'd1;
    hit = 1'b0; hit_w = '0; found = 1'b0; free_w = '0;
    for (int w = sacl_pkg::MaxWays - 1; w >= 0; w--) begin
      if (w < int'(acc_r.ways)) begin
        if (row.valid[w] && row.tag[w] == acc_r.tag) begin
          hit = 1'b1; hit_w = sacl_pkg::WayW'(w);
        end
        if (!row.valid[w]) begin
          found = 1'b1; free_w = sacl_pkg::WayW'(w);
        end
      end
    end
    // pairwise minimum tree; a tie keeps the lower way
    for (int w = 0; w < sacl_pkg::MaxWays; w++) begin
      lvl_w[w] = sacl_pkg::WayW'(w);
      lvl_s[w] = row.stamp[w];
      lvl_ok[w] = (w < int'(acc_r.ways));
    end
    for (int st = 1; st < sacl_pkg::MaxWays; st = st * 2) begin
      for (int i = 0; i < sacl_pkg::MaxWays; i = i + 2 * st) begin
        if (i + st < sacl_pkg::MaxWays) begin
          if (lvl_ok[i + st] && (!lvl_ok[i] || lvl_s[i] > lvl_s[i + st])) begin
            lvl_w[i] = lvl_w[i + st];
            lvl_s[i] = lvl_s[i + st];
            lvl_ok[i] = 1'b1;
          end
        end
      end
    end
    lru_w = lvl_w[0];
    evict = !hit && !found;
    pick = hit ? hit_w : (found ? free_w : lru_w);
    row_nxt = row;
    row_nxt.valid[pick] = 1'b1;
    row_nxt.tag[pick] = acc_r.tag;
    row_nxt.stamp[pick] = now;
    hits_nxt = sacl_pkg::sat_add(hits_r,
      hit ? (acc_r.modify ? 2'd2 : 2'd1) : {1'b0, acc_r.modify});
    misses_nxt = sacl_pkg::sat_add(misses_r, {1'b0, !hit});
    evicts_nxt = sacl_pkg::sat_add(evicts_r, {1'b0, evict});
    res.hit = hit;
    res.miss = !hit;
    res.eviction = evict;
    res.second_hit = acc_r.modify;
    res.hit_total = hits_nxt;
    res.miss_total = misses_nxt;
    res.eviction_total = evicts_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sacl_pkg::ST_IDLE;
      set_seen_r <= '0;
      hits_r <= '0;
      misses_r <= '0;
      evicts_r <= '0;
      out_full_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (do_update) begin
        set_seen_r[acc_r.set] <= 1'b1;
        hits_r <= hits_nxt;
        misses_r <= misses_nxt;
        evicts_r <= evicts_nxt;
        out_full_r <= 1'b1;
      end else if (out_pop && out_full_r) begin
        out_full_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_read) begin
      acc_r <= q_data;
      row_rd_r <= set_mem[q_data.set];
      cnt_rd_r <= cnt_mem[q_data.set];
    end
    if (do_update) begin
      set_mem[acc_r.set] <= row_nxt;
      cnt_mem[acc_r.set] <= now;
      out_r <= res;
    end
  end

  assign out_empty = !out_full_r;
  assign out_data = out_r;
endmodule

>>> sv/set_assoc_cache_lru_model.sv
// Top level of the tag-only set-associative LRU cache model.
// Each access passes through the back end's states in turn (issue, set
// read, update and write-back of one set row); no new access is taken until
// the last is written back; two classified accesses queue in the front end.
// A result register holds one result; the back end waits while it is unread.
// Set contents read as empty until a set is first touched after reset.
`timescale 1ns / 1ps
module set_assoc_cache_lru_model (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  input  sacl_pkg::in_item_t   in_data,
  output logic                 in_full,
  output logic                 out_empty,
  input  logic                 out_pop,
  output sacl_pkg::out_item_t  out_data,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [4:0]           cfg_data
);
  logic [2:0] set_bits_r;
  logic [3:0] ways_in_use_r;
  logic [4:0] block_bits_r;
  logic q_valid, q_take;
  sacl_pkg::acc_t q_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_bits_r <= 3'd0;
      ways_in_use_r <= 4'd1;
      block_bits_r <= 5'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        sacl_pkg::CfgSetBits:   set_bits_r <= cfg_data[2:0];
        sacl_pkg::CfgWaysInUse: ways_in_use_r <= cfg_data[3:0];
        sacl_pkg::CfgBlockBits: block_bits_r <= cfg_data;
        default: ;
      endcase
    end
  end

  sacl_front u_front (
    .clk, .rst_n, .in_push, .in_data, .in_full,
    .set_bits_r, .ways_in_use_r, .block_bits_r,
    .q_valid, .q_data, .q_take
  );

  sacl_back u_back (
    .clk, .rst_n, .q_valid, .q_data, .q_take,
    .out_empty, .out_pop, .out_data
  );
endmodule
